// ===== design/cbc_pkg.sv =====
// Shared constants and types of the cartridge bank controller.
package cbc_pkg;

   localparam int DEFAULT_RAM_BANKS     = 4;
   localparam int DEFAULT_ROM_BANK_BITS = 7;

   localparam int MAX_ROM_BANK_BITS = 7;
   localparam int RAM_BANK_AW       = 13;
   localparam int RAM_ADDR_W_MAX    = 15;
   localparam int ROM_OFFSET_W      = 14;
   localparam int ROM_ADDR_W        = 21;
   localparam int NUM_CLOCK_REGS    = 5;
   localparam int CLOCK_IDX_W       = 3;

   localparam logic       CMD_READ     = 1'b0;
   localparam logic       CMD_WRITE    = 1'b1;
   localparam logic [3:0] ENABLE_KEY   = 4'hA;
   localparam logic [7:0] LATCH_ARM    = 8'h00;
   localparam logic [7:0] LATCH_FIRE   = 8'h01;
   localparam logic [7:0] CLOCK_FIRST  = 8'h08;
   localparam logic [7:0] CLOCK_LAST   = 8'h0C;

   // Register windows of the low 32 KiB, picked by address bits 14:13.
   localparam logic [1:0] WIN_ENABLE   = 2'd0;
   localparam logic [1:0] WIN_ROM_BANK = 2'd1;
   localparam logic [1:0] WIN_SELECT   = 2'd2;
   localparam logic [1:0] WIN_LATCH    = 2'd3;

   localparam logic [2:0] RAM_WINDOW   = 3'b101;

   typedef struct packed {
      logic                      wr;
      logic                      rd;
      logic [RAM_ADDR_W_MAX-1:0] addr;
      logic [7:0]                wdata;
   } ram_req_type;

endpackage

// ===== design/cbc_ram.sv =====
// Single-port cartridge RAM with registered read data.
module cbc_ram
   import cbc_pkg::*;
#(
   parameter int RAM_BANKS = DEFAULT_RAM_BANKS
) (
   input  logic        clock,
   input  ram_req_type ram_req,
   output logic [7:0]  ram_q
);

   localparam int DEPTH = RAM_BANKS * (2 ** RAM_BANK_AW);
   localparam int AW    = $clog2(DEPTH);

   logic [7:0] mem [DEPTH];
   logic [7:0] q_ff;

   always_ff @(posedge clock) begin
      if (ram_req.wr) begin
         mem[ram_req.addr[AW-1:0]] <= ram_req.wdata;
      end else if (ram_req.rd) begin
         q_ff <= mem[ram_req.addr[AW-1:0]];
      end
   end

   assign ram_q = q_ff;

endmodule

// ===== design/cartridge_bank_controller_rtc.sv =====
// Cartridge bank controller with ROM banking, banked RAM and a latched clock register file.
// Each request is one bus access and yields exactly one response. A request is taken every
// cycle while the response register is empty or being drained; its response appears in that
// register on the next clock edge, and throughput is one request per cycle. The RAM is a
// single synchronous port, used by at most one request per cycle, and it needs no clearing
// pass after reset; bytes never written read back as unknown.
// The clock registers are only latched and written here; they do not count.
module cartridge_bank_controller_rtc
   import cbc_pkg::*;
#(
   parameter int RAM_BANKS     = DEFAULT_RAM_BANKS,
   parameter int ROM_BANK_BITS = DEFAULT_ROM_BANK_BITS
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // address[15:0], write_data[23:16]
   input  logic        req_tuser,   // command (0 read, 1 write)
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // rom_address[20:0], read_data[28:21], zero[31:29]
   output logic [2:0]  rsp_tuser    // claimed[0], rom_request[1], read_valid[2]
);

   localparam logic [7:0] BANK_MASK = 8'(((1 << ROM_BANK_BITS) - 1) & 8'h7F);

   logic [ROM_BANK_BITS-1:0] rom_bank_ff, rom_bank_in;
   logic [7:0]               select_ff, select_in;
   logic                     enable_ff, enable_in;
   logic                     armed_ff, armed_in;
   logic [7:0]               clock_live_ff [NUM_CLOCK_REGS];
   logic [7:0]               clock_live_in [NUM_CLOCK_REGS];
   logic [7:0]               clock_latched_ff [NUM_CLOCK_REGS];
   logic [7:0]               clock_latched_in [NUM_CLOCK_REGS];

   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     claimed_ff, claimed_in;
   logic                     rom_req_ff, rom_req_in;
   logic [ROM_ADDR_W-1:0]    rom_addr_ff, rom_addr_in;
   logic                     rd_valid_ff, rd_valid_in;
   logic                     from_ram_ff, from_ram_in;
   logic [7:0]               rd_data_ff, rd_data_in;

   logic                     accept;
   logic                     is_write;
   logic [15:0]              address;
   logic [7:0]               wdata;
   logic                     in_rom;
   logic                     in_ram;
   logic                     sel_is_ram;
   logic                     sel_is_clock;
   logic [CLOCK_IDX_W-1:0]   clock_idx;
   logic [7:0]               masked_bank;
   ram_req_type              ram_req;
   logic [7:0]               ram_q;

   assign req_tready   = !reset && (!rsp_valid_ff || rsp_tready);
   assign accept       = req_tvalid && req_tready;
   assign is_write     = (req_tuser == CMD_WRITE);
   assign address      = req_tdata[15:0];
   assign wdata        = req_tdata[23:16];
   assign in_rom       = !address[15];
   assign in_ram       = (address[15:13] == RAM_WINDOW);
   assign sel_is_ram   = (select_ff < 8'(RAM_BANKS));
   assign sel_is_clock = (select_ff >= CLOCK_FIRST) && (select_ff <= CLOCK_LAST);
   assign clock_idx    = CLOCK_IDX_W'(select_ff - CLOCK_FIRST);
   assign masked_bank  = wdata & BANK_MASK;

   always_comb begin
      rom_bank_in      = rom_bank_ff;
      select_in        = select_ff;
      enable_in        = enable_ff;
      armed_in         = armed_ff;
      clock_live_in    = clock_live_ff;
      clock_latched_in = clock_latched_ff;

      claimed_in  = claimed_ff;
      rom_req_in  = rom_req_ff;
      rom_addr_in = rom_addr_ff;
      rd_valid_in = rd_valid_ff;
      from_ram_in = from_ram_ff;
      rd_data_in  = rd_data_ff;

      ram_req.wr    = 1'b0;
      ram_req.rd    = 1'b0;
      ram_req.addr  = {select_ff[1:0], address[RAM_BANK_AW-1:0]};
      ram_req.wdata = wdata;

      rsp_valid_in = rsp_tready ? 1'b0 : rsp_valid_ff;

      if (accept) begin
         rsp_valid_in = 1'b1;
         claimed_in   = in_rom || in_ram;
         rom_req_in   = 1'b0;
         rom_addr_in  = '0;
         rd_valid_in  = 1'b0;
         from_ram_in  = 1'b0;
         rd_data_in   = '0;

         if (is_write) begin
            if (in_rom) begin
               unique case (address[14:13])
                  WIN_ENABLE: begin
                     enable_in = (wdata[3:0] == ENABLE_KEY);
                  end
                  WIN_ROM_BANK: begin
                     rom_bank_in = (masked_bank == 8'h00) ? ROM_BANK_BITS'(1)
                                                          : masked_bank[ROM_BANK_BITS-1:0];
                  end
                  WIN_SELECT: begin
                     select_in = wdata;
                  end
                  WIN_LATCH: begin
                     if (wdata == LATCH_ARM) begin
                        armed_in = 1'b1;
                     end else begin
                        if (armed_ff && wdata == LATCH_FIRE) begin
                           clock_latched_in = clock_live_ff;
                        end
                        armed_in = 1'b0;
                     end
                  end
                  default: begin
                  end
               endcase
            end else if (in_ram && enable_ff) begin
               if (sel_is_ram) begin
                  ram_req.wr = 1'b1;
               end else if (sel_is_clock) begin
                  clock_live_in[clock_idx] = wdata;
               end
            end
         end else begin
            if (in_rom) begin
               rom_req_in = 1'b1;
               // The low window always reads bank 0; the high window uses the bank register.
               rom_addr_in = {address[14] ? 7'(rom_bank_ff) : 7'd0,
                              address[ROM_OFFSET_W-1:0]};
            end else if (in_ram && enable_ff) begin
               if (sel_is_ram) begin
                  ram_req.rd  = 1'b1;
                  rd_valid_in = 1'b1;
                  from_ram_in = 1'b1;
               end else if (sel_is_clock) begin
                  rd_valid_in = 1'b1;
                  rd_data_in  = clock_latched_ff[clock_idx];
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rom_bank_ff      <= ROM_BANK_BITS'(1);
         select_ff        <= '0;
         enable_ff        <= 1'b0;
         armed_ff         <= 1'b0;
         clock_live_ff    <= '{default: '0};
         clock_latched_ff <= '{default: '0};
         rsp_valid_ff     <= 1'b0;
      end else begin
         rom_bank_ff      <= rom_bank_in;
         select_ff        <= select_in;
         enable_ff        <= enable_in;
         armed_ff         <= armed_in;
         clock_live_ff    <= clock_live_in;
         clock_latched_ff <= clock_latched_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      claimed_ff  <= claimed_in;
      rom_req_ff  <= rom_req_in;
      rom_addr_ff <= rom_addr_in;
      rd_valid_ff <= rd_valid_in;
      from_ram_ff <= from_ram_in;
      rd_data_ff  <= rd_data_in;
   end

   cbc_ram #(
      .RAM_BANKS(RAM_BANKS)
   ) u_ram (
      .clock  (clock),
      .ram_req(ram_req),
      .ram_q  (ram_q)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, from_ram_ff ? ram_q : rd_data_ff, rom_addr_ff};
   assign rsp_tuser  = {rd_valid_ff, rom_req_ff, claimed_ff};

`ifndef ASSERT_OFF
   a_bank_nonzero: assert property (@(posedge clock) disable iff (reset)
      rom_bank_ff != '0)
      else $error("ROM bank register holds zero");

   a_rom_xor_data: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tuser[1] && rsp_tuser[2]))
      else $error("response carries both a ROM request and read data");

   a_claim_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser[1] || rsp_tuser[2]) |-> rsp_tuser[0])
      else $error("response flags set on an unclaimed address");

   a_enable_write: assert property (@(posedge clock) disable iff (reset)
      accept && is_write && address[15:13] == 3'b000
      |=> enable_ff == ($past(wdata[3:0]) == ENABLE_KEY))
      else $error("enable register does not follow the enable write");
`endif

endmodule
